@@ sv/ffha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int unsigned ARENA_BYTES  = 65536;
   localparam int unsigned HEADER_BYTES = 17;
   localparam int unsigned SPLIT_SLACK  = 10;

   localparam int unsigned ADDR_W = $clog2(ARENA_BYTES);
   localparam int unsigned SIZE_W = 16;
   localparam int unsigned SUM_W  = ADDR_W + 2;

   typedef struct packed {
      logic              live;
      logic              used;
      logic              has_next;
      logic [ADDR_W-1:0] next;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   localparam int unsigned HDR_W = $bits(hdr_type);

   localparam hdr_type RESET_HDR = '{
      live:     1'b1,
      used:     1'b0,
      has_next: 1'b0,
      next:     '0,
      size:     SIZE_W'(ARENA_BYTES - HEADER_BYTES)
   };

   typedef enum logic [1:0] {
      WR_SPLIT,
      WR_GRANT,
      WR_BACK,
      WR_RETIRE
   } wr_sel_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_GRANT,
      RSP_OOM
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         rd;
      logic         rd_next;
      logic         cap_a;
      logic         cap_b;
      logic         step;
      logic         clr_used;
      logic         merge;
      logic         we;
      wr_sel_type   wsel;
      logic         push;
      rsp_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic in_free;
      logic in_foff_ok;
      logic a_live;
      logic a_used;
      logic a_has_next;
      logic a_fit;
      logic a_split;
      logic adjacent;
      logic b_used;
      logic out_free;
   } status_type;

endpackage

@@ sv/ffha_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/ffha_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for block walks, splits, forward merges and result hand-off.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ffha_pkg::status_type st,
   output ffha_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_RD,
      S_A_CAP,
      S_A_CHK,
      S_A_WNEW,
      S_A_WCUR,
      S_F_RD,
      S_F_CAP,
      S_F_CHK,
      S_M_CHK,
      S_M_RD,
      S_M_CAP,
      S_M_EVAL,
      S_WBACK,
      S_RESP
   } state_type;

   state_type              state_ff, state_in;
   ffha_pkg::rsp_kind_type kind_ff, kind_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.wsel     = ffha_pkg::WR_BACK;
      cmd.kind     = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               kind_in      = ffha_pkg::RSP_NONE;
               if (!st.in_free) begin
                  state_in = S_A_RD;
               end else if (st.in_foff_ok) begin
                  state_in = S_F_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_A_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_A_CAP;
         end
         S_A_CAP: begin
            cmd.cap_a = 1'b1;
            state_in  = S_A_CHK;
         end
         S_A_CHK: begin
            if (!st.a_live) begin
               kind_in  = ffha_pkg::RSP_OOM;
               state_in = S_RESP;
            end else if (!st.a_used && st.a_fit) begin
               state_in = st.a_split ? S_A_WNEW : S_A_WCUR;
            end else if (st.a_has_next) begin
               cmd.step = 1'b1;
               state_in = S_A_RD;
            end else begin
               kind_in  = ffha_pkg::RSP_OOM;
               state_in = S_RESP;
            end
         end
         S_A_WNEW: begin
            cmd.we   = 1'b1;
            cmd.wsel = ffha_pkg::WR_SPLIT;
            state_in = S_A_WCUR;
         end
         S_A_WCUR: begin
            cmd.we   = 1'b1;
            cmd.wsel = ffha_pkg::WR_GRANT;
            kind_in  = ffha_pkg::RSP_GRANT;
            state_in = S_RESP;
         end
         S_F_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_F_CAP;
         end
         S_F_CAP: begin
            cmd.cap_a = 1'b1;
            state_in  = S_F_CHK;
         end
         S_F_CHK: begin
            if (st.a_live) begin
               cmd.clr_used = 1'b1;
               state_in     = S_M_CHK;
            end else begin
               state_in = S_RESP;
            end
         end
         S_M_CHK: begin
            state_in = (st.a_has_next && st.adjacent) ? S_M_RD : S_WBACK;
         end
         S_M_RD: begin
            cmd.rd      = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = S_M_CAP;
         end
         S_M_CAP: begin
            cmd.cap_b = 1'b1;
            state_in  = S_M_EVAL;
         end
         S_M_EVAL: begin
            if (st.b_used) begin
               state_in = S_WBACK;
            end else begin
               cmd.merge = 1'b1;
               cmd.we    = 1'b1;
               cmd.wsel  = ffha_pkg::WR_RETIRE;
               state_in  = S_M_CHK;
            end
         end
         S_WBACK: begin
            cmd.we   = 1'b1;
            cmd.wsel = ffha_pkg::WR_BACK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= ffha_pkg::RSP_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   a_no_rd_and_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd && cmd.we))
      else $error("header read and write in the same cycle");

   a_cap_after_rd: assert property (@(posedge clock) disable iff (reset)
      (cmd.cap_a || cmd.cap_b) |-> $past(cmd.rd))
      else $error("header captured without a read the cycle before");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> st.out_free)
      else $error("result pushed over a pending result");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new item taken while one is in progress");

endmodule

@@ sv/ffha_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dpath
// Header store, block records, size arithmetic and the result register.
// ----------------------------------------------------------------------------
module ffha_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_cmd,
   input  logic [ffha_pkg::SIZE_W-1:0]    in_req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]    in_free_offset,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [ffha_pkg::ADDR_W-1:0]    rsp_payload_offset,
   output logic                           rsp_out_of_memory,
   input  ffha_pkg::cmd_type              cmd,
   output ffha_pkg::status_type           st
);

   localparam int unsigned AW = ffha_pkg::ADDR_W;
   localparam int unsigned SW = ffha_pkg::SUM_W;

   logic [ffha_pkg::SIZE_W-1:0] req_size_ff;
   logic [AW-1:0]               cur_ff;
   ffha_pkg::hdr_type           a_ff;
   ffha_pkg::hdr_type           b_ff;
   logic                        init0_ff;
   logic                        rd0_ff;
   logic                        rsp_valid_ff;
   logic [AW-1:0]               rsp_offset_ff;
   logic                        rsp_oom_ff;

   logic [AW-1:0]               raddr;
   logic [AW-1:0]               waddr;
   ffha_pkg::hdr_type           wdata;
   logic [ffha_pkg::HDR_W-1:0]  ram_rdata;
   ffha_pkg::hdr_type           rd_hdr;
   logic [SW-1:0]               nb_sum;
   logic [SW-1:0]               end_sum;
   logic [SW-1:0]               need_sum;
   logic                        split;

   assign raddr = cmd.rd_next ? a_ff.next : cur_ff;

   ffha_ram #(
      .WIDTH (ffha_pkg::HDR_W),
      .DEPTH (ffha_pkg::ARENA_BYTES)
   ) u_hdr_ram (
      .clock (clock),
      .we    (cmd.we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.rd),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   assign rd_hdr = (rd0_ff && !init0_ff) ? ffha_pkg::RESET_HDR
                                         : ffha_pkg::hdr_type'(ram_rdata);

   assign nb_sum   = SW'(cur_ff) + SW'(req_size_ff) + SW'(ffha_pkg::HEADER_BYTES);
   assign end_sum  = SW'(cur_ff) + SW'(a_ff.size) + SW'(ffha_pkg::HEADER_BYTES);
   assign need_sum = SW'(req_size_ff)
                   + SW'(ffha_pkg::HEADER_BYTES + ffha_pkg::SPLIT_SLACK);
   assign split    = (SW'(a_ff.size) >= need_sum)
                   && (nb_sum < SW'(ffha_pkg::ARENA_BYTES));

   always_comb begin
      waddr = cur_ff;
      wdata = a_ff;
      case (cmd.wsel)
         ffha_pkg::WR_SPLIT: begin
            waddr          = nb_sum[AW-1:0];
            wdata.size     = a_ff.size - req_size_ff
                           - ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES);
            wdata.next     = a_ff.next;
            wdata.has_next = a_ff.has_next;
            wdata.used     = 1'b0;
            wdata.live     = 1'b1;
         end
         ffha_pkg::WR_GRANT: begin
            wdata.used = 1'b1;
            wdata.live = 1'b1;
            if (split) begin
               wdata.size     = req_size_ff;
               wdata.next     = nb_sum[AW-1:0];
               wdata.has_next = 1'b1;
            end
         end
         ffha_pkg::WR_RETIRE: begin
            waddr      = a_ff.next;
            wdata      = b_ff;
            wdata.live = 1'b0;
         end
         default: begin
            waddr = cur_ff;
            wdata = a_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_size_ff <= in_req_size;
         cur_ff      <= in_cmd
                      ? in_free_offset - AW'(ffha_pkg::HEADER_BYTES)
                      : '0;
      end else if (cmd.step) begin
         cur_ff <= a_ff.next;
      end
      if (cmd.cap_a) begin
         a_ff <= rd_hdr;
      end else if (cmd.clr_used) begin
         a_ff.used <= 1'b0;
      end else if (cmd.merge) begin
         a_ff.size     <= a_ff.size + b_ff.size
                        + ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES);
         a_ff.next     <= b_ff.next;
         a_ff.has_next <= b_ff.has_next;
      end
      if (cmd.cap_b) begin
         b_ff <= rd_hdr;
      end
      if (cmd.rd) begin
         rd0_ff <= (raddr == '0);
      end
      if (cmd.push) begin
         rsp_offset_ff <= (cmd.kind == ffha_pkg::RSP_GRANT)
                        ? cur_ff + AW'(ffha_pkg::HEADER_BYTES) : '0;
         rsp_oom_ff    <= (cmd.kind == ffha_pkg::RSP_OOM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init0_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.we && waddr == '0) begin
            init0_ff <= 1'b1;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_payload_offset = rsp_offset_ff;
   assign rsp_out_of_memory  = rsp_oom_ff;

   always_comb begin
      st            = '0;
      st.in_free    = in_cmd;
      st.in_foff_ok = (in_free_offset >= AW'(ffha_pkg::HEADER_BYTES));
      st.a_live     = a_ff.live;
      st.a_used     = a_ff.used;
      st.a_has_next = a_ff.has_next;
      st.a_fit      = (a_ff.size >= req_size_ff);
      st.a_split    = split;
      st.adjacent   = (SW'(a_ff.next) == end_sum);
      st.b_used     = b_ff.used;
      st.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

@@ sv/first_fit_heap_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over a 64 KiB arena with forward merging on free.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// req_     in   tdata: req_size[15:0], free_offset[31:16]; tuser: cmd
// rsp_     out  tdata: payload_offset[15:0]; tuser: out_of_memory
//
// Allocate: each header walked is read, captured from the registered RAM read
// and checked; a fit writes the split header if any, then the grant header.
// Free: read, capture, check; per free adjacent block read, capture, merge;
// write-back. An offset below header size or a dead header goes to the reply.
// Reset: synchronous; no clearing pass, the first block is ready at once.
// A pending result holds the next item in its last cycle until taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // req_size[15:0], free_offset[31:16]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // payload_offset[15:0]
   output logic        rsp_tuser    // out_of_memory
);

   ffha_pkg::cmd_type    cmd;
   ffha_pkg::status_type st;

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   ffha_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .in_cmd             (req_tuser),
      .in_req_size        (req_tdata[15:0]),
      .in_free_offset     (req_tdata[31:16]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_payload_offset (rsp_tdata),
      .rsp_out_of_memory  (rsp_tuser),
      .cmd                (cmd),
      .st                 (st)
   );

endmodule
